>>> sv/eoi_pkg.sv
package eoi_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DAY_W  = 20;
    localparam int FRAC_W = 16;
    localparam int VAL_W  = 24;
    localparam int IDX_W  = 12;
    localparam int IN_W   = 120;
    localparam int OUT_W  = 72;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic CFG_FIRST_DAY = 1'b0;
    localparam logic CFG_END_DAY   = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic                     slot_ok;
        logic [DAY_W-1:0]         slot;
        logic [FRAC_W-1:0]        frac;
        logic signed [VAL_W-1:0]  ut1;
        logic signed [VAL_W-1:0]  px;
        logic signed [VAL_W-1:0]  py;
    } t_qent;

endpackage

>>> sv/eoi_front.sv
module eoi_front #(
    parameter int TABLE_DEPTH = eoi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [eoi_pkg::DAY_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [eoi_pkg::IN_W-1:0]      i_s_tdata,
    input  logic                          i_s_tkind,
    output logic                          o_push,
    output eoi_pkg::t_qent                o_push_data,
    input  logic                          i_full
);

    localparam logic [20:0] LAST_K = 21'(TABLE_DEPTH - 1);
    localparam logic [20:0] DEPTH_V = 21'(TABLE_DEPTH);

    logic [eoi_pkg::DAY_W-1:0] r_first_day;
    logic [eoi_pkg::DAY_W-1:0] r_end_day;

    logic [eoi_pkg::IDX_W-1:0]  idx;
    logic [eoi_pkg::DAY_W-1:0]  day;
    logic [eoi_pkg::DAY_W-1:0]  k;
    logic                       in_span;
    logic                       wr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_day <= '0;
            r_end_day   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                eoi_pkg::CFG_FIRST_DAY: r_first_day <= i_cfg_wdata;
                eoi_pkg::CFG_END_DAY:   r_end_day   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign idx = i_s_tdata[11:0];
    assign day = i_s_tdata[103:84];
    assign k   = day - r_first_day;

    assign in_span = (day >= r_first_day) && (day < r_end_day) && ({1'b0, k} < LAST_K);
    assign wr_ok   = {9'b0, idx} < DEPTH_V;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    always_comb begin
        o_push_data.kind    = i_s_tkind;
        o_push_data.slot_ok = (i_s_tkind == eoi_pkg::KIND_QUERY) ? in_span : wr_ok;
        o_push_data.slot    = (i_s_tkind == eoi_pkg::KIND_QUERY) ? k : {8'b0, idx};
        o_push_data.frac    = i_s_tdata[119:104];
        o_push_data.ut1     = i_s_tdata[35:12];
        o_push_data.px      = i_s_tdata[59:36];
        o_push_data.py      = i_s_tdata[83:60];
    end

`ifndef ASSERT_OFF
    a_below_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (i_s_tkind == eoi_pkg::KIND_QUERY) && (day < r_first_day)
        |-> !o_push_data.slot_ok)
        else $error("query below first day classified in range");
    a_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (i_s_tkind == eoi_pkg::KIND_QUERY) && (day >= r_end_day)
        |-> !o_push_data.slot_ok)
        else $error("query at or past end day classified in range");
`endif

endmodule

>>> sv/eoi_fifo.sv
module eoi_fifo #(
    parameter int DEPTH = eoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eoi_pkg::t_qent  i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_pop_valid,
    output eoi_pkg::t_qent  o_pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    eoi_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_pop;

    assign o_full      = (r_count == FULL);
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd];
    assign do_pop      = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !do_pop |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count lost a push");
`endif

endmodule

>>> sv/eoi_back.sv
module eoi_back #(
    parameter int TABLE_DEPTH = eoi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  eoi_pkg::t_qent                i_q_data,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [eoi_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                          o_m_tuser
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic signed [24:0] HALF_SEC = 25'sd524288;
    localparam logic signed [25:0] ONE_SEC  = 26'sd1048576;
    localparam logic signed [44:0] VMAX     = 45'sd8388607;
    localparam logic signed [44:0] VMIN     = -45'sd8388608;

    logic [eoi_pkg::OUT_W-1:0] r_mem [TABLE_DEPTH];

    logic        en;
    logic        pop;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;

    logic                        r_s1_v, r_s1_ok;
    logic [15:0]                 r_s1_r;
    logic [eoi_pkg::OUT_W-1:0]   r_s1_a, r_s1_b;

    logic                        r_s2_v, r_s2_ok;
    logic [15:0]                 r_s2_r;
    logic signed [23:0]          r_s2_a_ut, r_s2_a_px, r_s2_a_py;
    logic signed [26:0]          r_s2_du, r_s2_dx, r_s2_dy;

    logic                        r_s3_v, r_s3_ok;
    logic signed [23:0]          r_s3_a_ut, r_s3_a_px, r_s3_a_py;
    logic signed [43:0]          r_s3_p_ut, r_s3_p_px, r_s3_p_py;

    logic                        r_s4_v, r_s4_oor;
    logic [eoi_pkg::OUT_W-1:0]   r_s4_data;

    logic signed [23:0] a_ut, a_px, a_py, b_ut, b_px, b_py;
    logic signed [24:0] d_ut;
    logic signed [25:0] bu;
    logic signed [16:0] frac_s;

    function automatic logic [23:0] interp_sat(input logic signed [23:0] a,
                                               input logic signed [43:0] p);
        logic signed [44:0] s;
        s = 45'(a) + 45'(p >>> 16);
        if (s > VMAX) begin
            return 24'(VMAX);
        end else if (s < VMIN) begin
            return 24'(VMIN);
        end
        return s[23:0];
    endfunction

    assign en     = !r_s4_v || i_m_tready;
    assign pop    = en && i_q_valid;
    assign o_q_pop = en;
    assign addr_a = i_q_data.slot[AW-1:0];
    assign addr_b = addr_a + AW'(1);

    always_ff @(posedge i_clk) begin
        if (pop && (i_q_data.kind == eoi_pkg::KIND_WRITE) && i_q_data.slot_ok) begin
            r_mem[addr_a] <= {i_q_data.py, i_q_data.px, i_q_data.ut1};
        end
        if (pop && (i_q_data.kind == eoi_pkg::KIND_QUERY)) begin
            r_s1_a <= r_mem[addr_a];
            r_s1_b <= r_mem[addr_b];
        end
    end

    assign a_ut = r_s1_a[23:0];
    assign a_px = r_s1_a[47:24];
    assign a_py = r_s1_a[71:48];
    assign b_ut = r_s1_b[23:0];
    assign b_px = r_s1_b[47:24];
    assign b_py = r_s1_b[71:48];
    assign d_ut = 25'(b_ut) - 25'(a_ut);

    always_comb begin
        if (d_ut > HALF_SEC) begin
            bu = 26'(b_ut) - ONE_SEC;
        end else if (d_ut < -HALF_SEC) begin
            bu = 26'(b_ut) + ONE_SEC;
        end else begin
            bu = 26'(b_ut);
        end
    end

    assign frac_s = $signed({1'b0, r_s2_r});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= pop && (i_q_data.kind == eoi_pkg::KIND_QUERY);
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ok   <= i_q_data.slot_ok;
            r_s1_r    <= i_q_data.frac;

            r_s2_ok   <= r_s1_ok;
            r_s2_r    <= r_s1_r;
            r_s2_a_ut <= a_ut;
            r_s2_a_px <= a_px;
            r_s2_a_py <= a_py;
            r_s2_du   <= 27'(bu) - 27'(a_ut);
            r_s2_dx   <= 27'(b_px) - 27'(a_px);
            r_s2_dy   <= 27'(b_py) - 27'(a_py);

            r_s3_ok   <= r_s2_ok;
            r_s3_a_ut <= r_s2_a_ut;
            r_s3_a_px <= r_s2_a_px;
            r_s3_a_py <= r_s2_a_py;
            r_s3_p_ut <= 44'(frac_s) * 44'(r_s2_du);
            r_s3_p_px <= 44'(frac_s) * 44'(r_s2_dx);
            r_s3_p_py <= 44'(frac_s) * 44'(r_s2_dy);

            r_s4_oor  <= !r_s3_ok;
            if (r_s3_ok) begin
                r_s4_data <= {interp_sat(r_s3_a_py, r_s3_p_py),
                              interp_sat(r_s3_a_px, r_s3_p_px),
                              interp_sat(r_s3_a_ut, r_s3_p_ut)};
            end else begin
                r_s4_data <= '0;
            end
        end
    end

    assign o_m_tvalid = r_s4_v;
    assign o_m_tdata  = r_s4_data;
    assign o_m_tuser  = r_s4_oor;

`ifndef ASSERT_OFF
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_v && r_s4_oor |-> r_s4_data == '0)
        else $error("out of range result carries nonzero data");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s3_v |=> r_s4_v)
        else $error("result dropped between stages");
`endif

endmodule

>>> sv/earth_orientation_interpolator.sv
// a query's result passes the queue and the stage registers s1 to s4, later per queue entry waiting
// throughput: one item per cycle when not stalled, set by the single-issue read of the dual-read table memory
// write items take the same slot in the pipeline and give no result
// reset: synchronous active low, clears config registers, queue and stage valids
// table contents are not cleared by reset and stay undefined until written
module earth_orientation_interpolator #(
    parameter int TABLE_DEPTH = eoi_pkg::TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = eoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [eoi_pkg::DAY_W-1:0]  i_cfg_wdata,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // entry_index, ut1_in, pole_x_in, pole_y_in, query_day, day_fraction
    input  logic [eoi_pkg::IN_W-1:0]   i_s_tdata,
    // kind
    input  logic [0:0]                 i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // ut1_out, pole_x_out, pole_y_out
    output logic [eoi_pkg::OUT_W-1:0]  o_m_tdata,
    // out_of_range
    output logic [0:0]                 o_m_tuser
);

    logic           push;
    logic           full;
    logic           q_valid;
    logic           q_pop;
    eoi_pkg::t_qent push_data;
    eoi_pkg::t_qent q_data;

    eoi_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tkind   (i_s_tuser[0]),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    eoi_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (q_pop),
        .o_pop_valid (q_valid),
        .o_pop_data  (q_data)
    );

    eoi_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser[0])
    );

endmodule

>>> tb/tb_earth_orientation_interpolator.sv
module tb_earth_orientation_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = eoi_pkg::TABLE_DEPTH_DEF;
    localparam int VW          = eoi_pkg::VAL_W;
    localparam int DW          = eoi_pkg::DAY_W;
    localparam int FW          = eoi_pkg::FRAC_W;
    localparam int IW          = eoi_pkg::IDX_W;
    localparam int VAL_MAX     = 8388607;
    localparam int VAL_MIN     = -8388608;
    localparam int LEAP_LIMIT  = 1 << 19;
    localparam int LEAP_STEP   = 1 << 20;
    localparam int DAY_MAX     = (1 << DW) - 1;
    localparam int WINDOW      = 48;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        logic                 kind;
        logic [IW-1:0]        idx;
        logic signed [VW-1:0] ut1;
        logic signed [VW-1:0] px;
        logic signed [VW-1:0] py;
        logic [DW-1:0]        day;
        logic [FW-1:0]        frac;
    } t_eop_item;

    typedef struct {
        logic signed [VW-1:0] ut1;
        logic signed [VW-1:0] px;
        logic signed [VW-1:0] py;
    } t_eop_entry;

    typedef struct {
        logic signed [VW-1:0] ut1;
        logic signed [VW-1:0] px;
        logic signed [VW-1:0] py;
        logic                 oor;
    } t_eop_answer;

    logic                      i_clk     = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic                      cfg_addr  = eoi_pkg::CFG_FIRST_DAY;
    logic [DW-1:0]             cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic [eoi_pkg::IN_W-1:0]  s_tdata   = '0;
    logic [0:0]                s_tuser   = '0;
    logic                      m_tready  = 1'b0;
    logic                      o_s_tready;
    logic                      o_m_tvalid;
    logic [eoi_pkg::OUT_W-1:0] o_m_tdata;
    logic [0:0]                o_m_tuser;

    earth_orientation_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state: mirrored table and span registers
    t_eop_entry  eop_mirror [SLOTS];
    int          span_first = 0;
    int          span_end   = 0;

    // generator view: which slots are safe to read
    bit          gen_written [SLOTS];
    int          gen_fd = 0;
    int          gen_ed = 0;

    t_eop_item   stim_q [$];
    t_eop_answer pending_answers [$];
    t_eop_item   cur_item;

    int n_in = 0, n_writes = 0, n_queries = 0, n_oor = 0, n_leaps = 0;
    int n_answers = 0, n_fail = 0, n_spans = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit pressure_armed = 1'b0;
    logic calm;

    assign calm = (n_in >= 800) && (n_in < 1100);

    function automatic logic signed [VW-1:0] lerp24(longint lo, longint hi,
                                                     logic [FW-1:0] r);
        longint v;
        v = lo + ((longint'(r) * (hi - lo)) >>> 16);
        if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
        if (v < longint'(VAL_MIN)) v = longint'(VAL_MIN);
        return v[VW-1:0];
    endfunction

    function automatic t_eop_answer answer_query(logic [DW-1:0] day, logic [FW-1:0] r);
        t_eop_answer ans;
        t_eop_entry  a, b;
        longint      k, au, bu;
        logic [IW-1:0] ka;
        bit          ok;
        ok = (int'(day) >= span_first) && (int'(day) < span_end);
        k = longint'(day) - longint'(span_first);
        if (ok && k + 1 >= longint'(SLOTS)) ok = 1'b0;
        if (!ok) begin
            ans = '{ut1: '0, px: '0, py: '0, oor: 1'b1};
            return ans;
        end
        ka = k[IW-1:0];
        a = eop_mirror[ka];
        b = eop_mirror[ka + IW'(1)];
        au = longint'($signed(a.ut1));
        bu = longint'($signed(b.ut1));
        // leap second taken out of the later day
        if (bu - au > longint'(LEAP_LIMIT)) begin
            bu = bu - longint'(LEAP_STEP);
            n_leaps++;
        end else if (bu - au < -longint'(LEAP_LIMIT)) begin
            bu = bu + longint'(LEAP_STEP);
            n_leaps++;
        end
        ans.ut1 = lerp24(au, bu, r);
        ans.px  = lerp24(longint'($signed(a.px)), longint'($signed(b.px)), r);
        ans.py  = lerp24(longint'($signed(a.py)), longint'($signed(b.py)), r);
        ans.oor = 1'b0;
        return ans;
    endfunction

    // a query is allowed unless it would read a slot never written
    function automatic bit reads_written(int day);
        int k;
        if (day < gen_fd || day >= gen_ed) return 1'b1;
        k = day - gen_fd;
        if (k + 1 >= SLOTS) return 1'b1;
        return gen_written[IW'(k)] && gen_written[IW'(k + 1)];
    endfunction

    function automatic logic signed [VW-1:0] rand_val();
        logic [31:0] u;
        int          sel;
        u = $urandom;
        sel = $urandom_range(0, 3);
        case (sel)
            0: return u[VW-1:0];
            1: return VW'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            2: begin
                case ($urandom_range(0, 3))
                    0: return VW'(VAL_MIN);
                    1: return VW'(VAL_MAX);
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                // around the half-second threshold
                if (u[0]) return VW'(LEAP_LIMIT + int'($urandom_range(0, 4)) - 2);
                return VW'(-LEAP_LIMIT - int'($urandom_range(0, 4)) + 2);
            end
        endcase
    endfunction

    task automatic push_write(int idx, int ut1, int px, int py);
        t_eop_item it;
        it.kind = eoi_pkg::KIND_WRITE;
        it.idx  = IW'(idx);
        it.ut1  = VW'(ut1);
        it.px   = VW'(px);
        it.py   = VW'(py);
        it.day  = DW'($urandom);
        it.frac = FW'($urandom);
        gen_written[it.idx] = 1'b1;
        stim_q.push_back(it);
    endtask

    task automatic push_query(int day, int frac);
        t_eop_item it;
        it.kind = eoi_pkg::KIND_QUERY;
        it.idx  = IW'($urandom);
        it.ut1  = VW'($urandom);
        it.px   = VW'($urandom);
        it.py   = VW'($urandom);
        it.day  = DW'(day);
        it.frac = FW'(frac);
        stim_q.push_back(it);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (stim_q.size() != 0 || s_tvalid || pending_answers.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_span(int fd, int ed);
        drain();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= eoi_pkg::CFG_FIRST_DAY;
        cfg_wdata <= DW'(fd);
        @(posedge i_clk);
        cfg_addr  <= eoi_pkg::CFG_END_DAY;
        cfg_wdata <= DW'(ed);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        gen_fd = fd;
        gen_ed = ed;
        n_spans++;
    endtask

    // sender side: transfer bookkeeping, prediction and item issue
    always @(posedge i_clk) begin : drive_items
        t_eop_answer ans;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            span_first = 0;
            span_end   = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == eoi_pkg::CFG_FIRST_DAY) span_first = int'(cfg_wdata);
                else span_end = int'(cfg_wdata);
            end
            if (s_tvalid && o_s_tready) begin
                n_in++;
                if (cur_item.kind == eoi_pkg::KIND_WRITE) begin
                    eop_mirror[cur_item.idx] = '{ut1: cur_item.ut1, px: cur_item.px,
                                                 py: cur_item.py};
                    n_writes++;
                end else begin
                    ans = answer_query(cur_item.day, cur_item.frac);
                    pending_answers.push_back(ans);
                    n_queries++;
                    if (ans.oor) n_oor++;
                end
            end
            if (!s_tvalid || o_s_tready) begin
                if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                    cur_item = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.frac, cur_item.day, cur_item.py, cur_item.px,
                                 cur_item.ut1, cur_item.idx};
                    s_tuser  <= cur_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_armed && !hold_done && pending_answers.size() >= 2) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver side: compare each result with the oldest prediction
    always @(posedge i_clk) begin : check_answers
        t_eop_answer want;
        t_eop_answer got;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                n_answers++;
                got.ut1 = o_m_tdata[VW-1:0];
                got.px  = o_m_tdata[2*VW-1:VW];
                got.py  = o_m_tdata[3*VW-1:2*VW];
                got.oor = o_m_tuser[0];
                if (pending_answers.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result ut1=%0d px=%0d py=%0d oor=%0b",
                                 got.ut1, got.px, got.py, got.oor);
                end else begin
                    want = pending_answers.pop_front();
                    if (got.ut1 !== want.ut1 || got.px !== want.px ||
                        got.py !== want.py || got.oor !== want.oor) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("result %0d: exp ut1=%0d px=%0d py=%0d oor=%0b",
                                     n_answers, want.ut1, want.px, want.py, want.oor);
                            $display("result %0d: got ut1=%0d px=%0d py=%0d oor=%0b",
                                     n_answers, got.ut1, got.px, got.py, got.oor);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 26);
        end
    end

    initial begin : stimulus
        int fd, ed, base, mode, p, day;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // span still at reset: every query fails
        push_write(0, 1, 2, 3);
        push_query(0, 0);
        push_query(DAY_MAX, 16'hFFFF);

        set_span(0, DAY_MAX);
        push_write(0, VAL_MAX, VAL_MIN, 0);
        push_write(1, VAL_MIN, VAL_MAX, -1);
        push_write(2, VAL_MIN, 0, 0);
        push_write(3, VAL_MIN + LEAP_LIMIT + 1, 5, -5);
        push_write(5, VAL_MAX, -7, 7);
        push_write(6, VAL_MAX - LEAP_LIMIT - 1, 7, -7);
        push_write(8, 0, 1000, -1000);
        push_write(9, LEAP_LIMIT, -3, 3);
        push_write(10, -LEAP_LIMIT - 1, 0, 0);
        push_write(SLOTS - 2, 12345, -12345, 777);
        push_write(SLOTS - 1, -54321, 54321, -777);
        push_query(0, 0);
        push_query(0, 16'hFFFF);
        push_query(2, 16'hFFFF);
        push_query(5, 16'hFFFF);
        push_query(8, 16'h8000);
        push_query(9, 1);
        push_query(SLOTS - 2, 16'h1234);
        // beyond the last table slot
        push_query(SLOTS - 1, 16'h1234);

        set_span(100, 104);
        push_query(99, 16'h4000);
        push_query(100, 16'hC000);
        push_query(104, 16'h4000);

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 3;
            fd = $urandom_range(0, DAY_MAX - 4200);
            base = (mode == 2) ? SLOTS - WINDOW : $urandom_range(0, SLOTS - WINDOW);
            if (mode == 0) ed = fd + base + $urandom_range(0, WINDOW + 20);
            else if (mode == 1) ed = DAY_MAX;
            else ed = fd + SLOTS + 8;
            if (ed > DAY_MAX) ed = DAY_MAX;
            set_span(fd, ed);
            if (ph == 1) pressure_armed = 1'b1;
            repeat (200) begin
                p = $urandom_range(0, 99);
                if (p < 30) begin
                    push_write(base + $urandom_range(0, WINDOW - 1),
                               int'(rand_val()), int'(rand_val()), int'(rand_val()));
                end else if (p < 35) begin
                    push_write($urandom_range(0, SLOTS - 1),
                               int'(rand_val()), int'(rand_val()), int'(rand_val()));
                end else begin
                    if (p < 85) day = fd + base + $urandom_range(0, WINDOW - 1);
                    else if (p < 92) day = $urandom_range(0, DAY_MAX);
                    else if (p < 95) day = fd - 1;
                    else if (p < 98) day = ed;
                    else day = ed - 1;
                    if (day < 0 || !reads_written(day)) day = ed;
                    push_query(day, $urandom_range(0, 16'hFFFF));
                end
            end
        end

        // top of both registers
        set_span(DAY_MAX, DAY_MAX);
        repeat (40) push_query($urandom_range(DAY_MAX - 3, DAY_MAX), $urandom_range(0, 16'hFFFF));

        drain();
        n_fail += pending_answers.size();
        $display("%0d input transfers: %0d table writes, %0d queries, %0d out of span",
                 n_in, n_writes, n_queries, n_oor);
        $display("%0d leap second fixes over %0d span settings, one %0d-cycle receiver stall",
                 n_leaps, n_spans, HOLD_CYCLES);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d failures", n_fail);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400us;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
